### rtl/core/allist_pkg.sv
package allist_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam int CMD_W    = 4;
  localparam int POS_W    = 3;
  localparam int TEXT_W   = 64;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int SLOT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LIST      = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_POS,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS_HEAD,
    OP_TAKE_AFTER,
    OP_LINK_CUR,
    OP_DEL_HEAD,
    OP_DEL_AFTER,
    OP_CLEAR
  } dp_op_t;

  typedef enum logic [1:0] {
    SL_ZERO,
    SL_FREE,
    SL_NEW,
    SL_CUR
  } slot_sel_t;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    rd_sel_t             rd_sel;
    dp_op_t              op;
    logic                res_en;
    logic [STATUS_W-1:0] res_status;
    slot_sel_t           slot_sel;
    logic                emit;
  } dp_ctl_t;

  typedef struct packed {
    logic full;
    logic head_valid;
    logic pos_ok;
    logic rd_has_next;
    logic at_head;
  } dp_stat_t;

endpackage

### rtl/core/allist_dp.sv
module allist_dp #(
  parameter int SLOTS = allist_pkg::SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  allist_pkg::dp_ctl_t                 ctl,
  output allist_pkg::dp_stat_t                stat,
  input  logic [allist_pkg::POS_W-1:0]        position,
  input  logic [allist_pkg::TEXT_W-1:0]       brand_text,
  input  logic [allist_pkg::TEXT_W-1:0]       colour_text,
  input  logic [allist_pkg::SIZE_W-1:0]       item_size,
  output logic                                result_valid,
  output logic [allist_pkg::STATUS_W-1:0]     status,
  output logic [allist_pkg::COUNT_W-1:0]      element_count,
  output logic [allist_pkg::SLOT_W-1:0]       slot_index,
  output logic [allist_pkg::TEXT_W-1:0]       out_brand,
  output logic [allist_pkg::TEXT_W-1:0]       out_colour,
  output logic [allist_pkg::SIZE_W-1:0]       out_size,
  output logic                                last_result
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int LINK_W = IDX_W + 1;

  // link entry: {has_next, next slot}
  logic [LINK_W-1:0]              link_mem [SLOTS];
  logic [allist_pkg::TEXT_W-1:0]  brand_mem [SLOTS];
  logic [allist_pkg::TEXT_W-1:0]  colour_mem [SLOTS];
  logic [allist_pkg::SIZE_W-1:0]  size_mem [SLOTS];

  logic [LINK_W-1:0]              link_rd;
  logic [allist_pkg::TEXT_W-1:0]  brand_rd;
  logic [allist_pkg::TEXT_W-1:0]  colour_rd;
  logic [allist_pkg::SIZE_W-1:0]  size_rd;

  logic [SLOTS-1:0]               used;
  logic                           head_valid;
  logic [IDX_W-1:0]               head;
  logic [CNT_W-1:0]               cnt;
  logic [CNT_W-1:0]               cnt_next;
  logic [IDX_W-1:0]               cur;
  logic [IDX_W-1:0]               prev;
  logic [IDX_W-1:0]               new_slot;
  logic [IDX_W-1:0]               free_slot;

  logic [allist_pkg::POS_W-1:0]   pos_q;
  logic [allist_pkg::TEXT_W-1:0]  brand_q;
  logic [allist_pkg::TEXT_W-1:0]  colour_q;
  logic [allist_pkg::SIZE_W-1:0]  size_q;

  logic [IDX_W-1:0]               pos_idx;
  logic                           pos_in;
  logic                           pos_ok;
  logic                           rd_has;
  logic [IDX_W-1:0]               rd_next;
  logic [IDX_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [LINK_W-1:0]              wr_data;
  logic                           data_we;
  logic [IDX_W-1:0]               res_slot;

  logic [IDX_W-1:0]               slot_q;
  logic [CNT_W-1:0]               count_q;

  assign rd_has  = link_rd[LINK_W-1];
  assign rd_next = link_rd[IDX_W-1:0];
  assign pos_idx = IDX_W'(pos_q);
  assign pos_in  = 32'(pos_q) < SLOTS;
  assign pos_ok  = pos_in && used[pos_idx];

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) free_slot = IDX_W'(i);
    end
  end

  always_comb begin
    stat.full        = (cnt == CNT_W'(SLOTS));
    stat.head_valid  = head_valid;
    stat.pos_ok      = pos_ok;
    stat.rd_has_next = rd_has;
    stat.at_head     = (cur == head);
  end

  always_comb begin
    case (ctl.rd_sel)
      allist_pkg::RD_HEAD: rd_addr = head;
      allist_pkg::RD_POS:  rd_addr = pos_idx;
      allist_pkg::RD_NEXT: rd_addr = rd_next;
      default:             rd_addr = head;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_slot;
    wr_data = {head_valid, head};
    data_we = 1'b0;
    case (ctl.op)
      allist_pkg::OP_INS_HEAD: begin
        wr_en   = 1'b1;
        data_we = 1'b1;
      end
      allist_pkg::OP_TAKE_AFTER: begin
        // new entry inherits the link of its predecessor
        wr_en   = 1'b1;
        wr_data = link_rd;
        data_we = 1'b1;
      end
      allist_pkg::OP_LINK_CUR: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = {1'b1, new_slot};
      end
      allist_pkg::OP_DEL_AFTER: begin
        // bypass the removed entry
        wr_en   = 1'b1;
        wr_addr = prev;
        wr_data = link_rd;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (ctl.op) inside
      allist_pkg::OP_INS_HEAD, allist_pkg::OP_TAKE_AFTER: cnt_next = cnt + 1'b1;
      allist_pkg::OP_DEL_HEAD, allist_pkg::OP_DEL_AFTER:  cnt_next = cnt - 1'b1;
      allist_pkg::OP_CLEAR:                               cnt_next = '0;
      default:                                            cnt_next = cnt;
    endcase
  end

  always_comb begin
    case (ctl.slot_sel)
      allist_pkg::SL_ZERO: res_slot = '0;
      allist_pkg::SL_FREE: res_slot = free_slot;
      allist_pkg::SL_NEW:  res_slot = new_slot;
      allist_pkg::SL_CUR:  res_slot = cur;
      default:             res_slot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (data_we) begin
      brand_mem[free_slot]  <= brand_q;
      colour_mem[free_slot] <= colour_q;
      size_mem[free_slot]   <= size_q;
    end
    if (ctl.rd_en) begin
      link_rd   <= link_mem[rd_addr];
      brand_rd  <= brand_mem[rd_addr];
      colour_rd <= colour_mem[rd_addr];
      size_rd   <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      head_valid   <= 1'b0;
      head         <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      cnt          <= cnt_next;
      result_valid <= ctl.res_en;
      case (ctl.op)
        allist_pkg::OP_INS_HEAD: begin
          used[free_slot] <= 1'b1;
          head            <= free_slot;
          head_valid      <= 1'b1;
        end
        allist_pkg::OP_TAKE_AFTER: used[free_slot] <= 1'b1;
        allist_pkg::OP_DEL_HEAD: begin
          used[cur]  <= 1'b0;
          head_valid <= rd_has;
          head       <= rd_next;
        end
        allist_pkg::OP_DEL_AFTER: used[cur] <= 1'b0;
        allist_pkg::OP_CLEAR: begin
          used       <= '0;
          head_valid <= 1'b0;
          head       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos_q    <= position;
      brand_q  <= brand_text;
      colour_q <= colour_text;
      size_q   <= item_size;
    end
    if (ctl.rd_en) begin
      cur <= rd_addr;
      if (ctl.rd_sel == allist_pkg::RD_NEXT) prev <= cur;
    end
    if (ctl.op == allist_pkg::OP_INS_HEAD || ctl.op == allist_pkg::OP_TAKE_AFTER) begin
      new_slot <= free_slot;
    end
    if (ctl.res_en) begin
      status      <= ctl.res_status;
      count_q     <= cnt_next;
      slot_q      <= res_slot;
      out_brand   <= ctl.emit ? brand_rd  : '0;
      out_colour  <= ctl.emit ? colour_rd : '0;
      out_size    <= ctl.emit ? size_rd   : '0;
      last_result <= ctl.emit ? !rd_has   : 1'b1;
    end
  end

  assign slot_index    = allist_pkg::SLOT_W'(slot_q);
  assign element_count = allist_pkg::COUNT_W'(count_q);

endmodule

### rtl/core/allist_ctrl.sv
module allist_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [allist_pkg::CMD_W-1:0]  cmd,
  input  allist_pkg::dp_stat_t          stat,
  output logic                          busy,
  output allist_pkg::dp_ctl_t           ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_AT,
    S_INS_FIX,
    S_TAIL_WALK,
    S_DEL_HEAD,
    S_DEL_AFT1,
    S_DEL_AFT2,
    S_LIST
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [allist_pkg::CMD_W-1:0] cmd_q;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    ctl.load       = 1'b0;
    ctl.rd_en      = 1'b0;
    ctl.rd_sel     = allist_pkg::RD_HEAD;
    ctl.op         = allist_pkg::OP_NONE;
    ctl.res_en     = 1'b0;
    ctl.res_status = allist_pkg::ST_OK;
    ctl.slot_sel   = allist_pkg::SL_ZERO;
    ctl.emit       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_IDLE;
        unique case (cmd_q)
          allist_pkg::CMD_INS_HEAD: begin
            ctl.res_en = 1'b1;
            if (stat.full) begin
              ctl.res_status = allist_pkg::ST_FULL;
            end else begin
              ctl.op       = allist_pkg::OP_INS_HEAD;
              ctl.slot_sel = allist_pkg::SL_FREE;
            end
          end
          allist_pkg::CMD_INS_AFTER: begin
            if (stat.full) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_FULL;
            end else if (!stat.pos_ok) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_BAD;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = allist_pkg::RD_POS;
              state_next = S_INS_AT;
            end
          end
          allist_pkg::CMD_INS_TAIL: begin
            if (stat.full) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_FULL;
            end else if (!stat.head_valid) begin
              ctl.res_en   = 1'b1;
              ctl.op       = allist_pkg::OP_INS_HEAD;
              ctl.slot_sel = allist_pkg::SL_FREE;
            end else begin
              ctl.rd_en  = 1'b1;
              state_next = S_TAIL_WALK;
            end
          end
          allist_pkg::CMD_DEL_HEAD: begin
            if (!stat.head_valid) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_EMPTY;
            end else begin
              ctl.rd_en  = 1'b1;
              state_next = S_DEL_HEAD;
            end
          end
          allist_pkg::CMD_DEL_AFTER: begin
            if (!stat.head_valid) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_EMPTY;
            end else if (!stat.pos_ok) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_BAD;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = allist_pkg::RD_POS;
              state_next = S_DEL_AFT1;
            end
          end
          allist_pkg::CMD_DEL_TAIL: begin
            if (!stat.head_valid) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_EMPTY;
            end else begin
              ctl.rd_en  = 1'b1;
              state_next = S_TAIL_WALK;
            end
          end
          allist_pkg::CMD_CLEAR: begin
            ctl.res_en = 1'b1;
            ctl.op     = allist_pkg::OP_CLEAR;
          end
          allist_pkg::CMD_COUNT: begin
            ctl.res_en = 1'b1;
          end
          allist_pkg::CMD_LIST: begin
            if (!stat.head_valid) begin
              ctl.res_en     = 1'b1;
              ctl.res_status = allist_pkg::ST_EMPTY;
            end else begin
              ctl.rd_en  = 1'b1;
              state_next = S_LIST;
            end
          end
          default: begin
            ctl.res_en     = 1'b1;
            ctl.res_status = allist_pkg::ST_BAD;
          end
        endcase
      end

      S_INS_AT: begin
        ctl.op     = allist_pkg::OP_TAKE_AFTER;
        state_next = S_INS_FIX;
      end

      S_INS_FIX: begin
        ctl.op       = allist_pkg::OP_LINK_CUR;
        ctl.res_en   = 1'b1;
        ctl.slot_sel = allist_pkg::SL_NEW;
        state_next   = S_IDLE;
      end

      S_TAIL_WALK: begin
        if (stat.rd_has_next) begin
          // advance one link
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = allist_pkg::RD_NEXT;
        end else if (cmd_q == allist_pkg::CMD_INS_TAIL) begin
          ctl.op     = allist_pkg::OP_TAKE_AFTER;
          state_next = S_INS_FIX;
        end else begin
          ctl.op       = stat.at_head ? allist_pkg::OP_DEL_HEAD : allist_pkg::OP_DEL_AFTER;
          ctl.res_en   = 1'b1;
          ctl.slot_sel = allist_pkg::SL_CUR;
          state_next   = S_IDLE;
        end
      end

      S_DEL_HEAD: begin
        ctl.op       = allist_pkg::OP_DEL_HEAD;
        ctl.res_en   = 1'b1;
        ctl.slot_sel = allist_pkg::SL_CUR;
        state_next   = S_IDLE;
      end

      S_DEL_AFT1: begin
        if (!stat.rd_has_next) begin
          // nothing follows the given slot
          ctl.res_en     = 1'b1;
          ctl.res_status = allist_pkg::ST_BAD;
          state_next     = S_IDLE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = allist_pkg::RD_NEXT;
          state_next = S_DEL_AFT2;
        end
      end

      S_DEL_AFT2: begin
        ctl.op       = allist_pkg::OP_DEL_AFTER;
        ctl.res_en   = 1'b1;
        ctl.slot_sel = allist_pkg::SL_CUR;
        state_next   = S_IDLE;
      end

      S_LIST: begin
        ctl.res_en   = 1'b1;
        ctl.slot_sel = allist_pkg::SL_CUR;
        ctl.emit     = 1'b1;
        if (stat.rd_has_next) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = allist_pkg::RD_NEXT;
        end else begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
      if (ctl.load) cmd_q <= cmd;
    end
  end

endmodule

### rtl/core/array_linked_list_unit.sv
// Channel   Handshake               Payload
// request   start, busy             cmd, position, brand_text, colour_text, item_size
// result    result_valid (1 cycle)  status, element_count, slot_index, out_brand,
//                                   out_colour, out_size, last_result
//
// A request is taken when start is high and busy is low; busy then stays high
// until the cycle of the final result. Decode has a state of its own; each link hop
// goes through the registered read of the link memory: count, clear, insert at
// head and requests refused at decode give their result from decode, insert after
// passes S_INS_AT and S_INS_FIX, delete reads one or two links, tail operations walk
// the list to its end, list gives its first result once the head is read and one more each cycle after that.
// Synchronous reset frees all slots at once.
// Results cannot be stalled; each one is valid for exactly one cycle.
module array_linked_list_unit #(
  parameter int SLOTS = allist_pkg::SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [allist_pkg::CMD_W-1:0]        cmd,
  input  logic [allist_pkg::POS_W-1:0]        position,
  input  logic [allist_pkg::TEXT_W-1:0]       brand_text,
  input  logic [allist_pkg::TEXT_W-1:0]       colour_text,
  input  logic [allist_pkg::SIZE_W-1:0]       item_size,
  output logic                                result_valid,
  output logic [allist_pkg::STATUS_W-1:0]     status,
  output logic [allist_pkg::COUNT_W-1:0]      element_count,
  output logic [allist_pkg::SLOT_W-1:0]       slot_index,
  output logic [allist_pkg::TEXT_W-1:0]       out_brand,
  output logic [allist_pkg::TEXT_W-1:0]       out_colour,
  output logic [allist_pkg::SIZE_W-1:0]       out_size,
  output logic                                last_result
);

  allist_pkg::dp_ctl_t  ctl;
  allist_pkg::dp_stat_t stat;

  allist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  allist_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .position      (position),
    .brand_text    (brand_text),
    .colour_text   (colour_text),
    .item_size     (item_size),
    .result_valid  (result_valid),
    .status        (status),
    .element_count (element_count),
    .slot_index    (slot_index),
    .out_brand     (out_brand),
    .out_colour    (out_colour),
    .out_size      (out_size),
    .last_result   (last_result)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_list_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |=> result_valid)
    else $error("gap inside list output");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |-> !busy)
    else $error("final result while still busy");

  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != allist_pkg::ST_OK |-> last_result)
    else $error("failed request without last flag");
`endif

endmodule
